// ===== rtl/kbq_pkg.sv =====
package kbq_pkg;

	// character queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = FILL_W + 1;

	// key bitmap size
	localparam int NUM_KEYCODES = 256;

	// queue between front and back
	localparam int IQ_DEPTH = 2;
	localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
	localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

	// fixed field widths
	localparam int COUNT_W = 7;
	localparam int TICK_W  = 16;

	localparam logic [7:0] RESET_CODE     = 8'hFF;
	localparam logic [7:0] HID_A          = 8'd4;
	localparam logic [7:0] HID_1          = 8'd30;
	localparam logic [7:0] HID_0          = 8'd39;
	localparam logic [7:0] ASCII_A        = 8'h41;
	localparam logic [7:0] ASCII_1        = 8'h31;
	localparam logic [7:0] ASCII_0        = 8'h30;
	localparam logic [7:0] CASE_DIFF      = 8'h20;
	localparam logic [7:0] CTRL_CHAR_MASK = 8'h1F;

	// item kinds
	typedef enum logic [1:0] {
		CMD_KEY  = 2'd0,
		CMD_TICK = 2'd1,
		CMD_POP  = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_REPEAT_START  = 2'd0,
		REG_REPEAT_PERIOD = 2'd1,
		REG_SHIFT_MASK    = 2'd2,
		REG_CONTROL_MASK  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0] repeat_start;
		logic [TICK_W-1:0] repeat_period;
		logic [7:0]        shift_mask;
		logic [7:0]        control_mask;
	} kbq_cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		cmd_t       cmd;
		logic       down;
		logic [7:0] code;
		logic [7:0] mods;
		logic [7:0] ch;
	} kbq_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} kbq_qstat_t;

	typedef struct packed {
		logic [7:0]         char_out;
		logic               char_available;
		logic [COUNT_W-1:0] fifo_count;
		logic               key_is_down;
		logic [7:0]         held_modifiers;
	} kbq_result_t;

	// US layout key to character
	function automatic logic [7:0] map_char(input logic [7:0] code, input logic shift,
		input logic ctrl);
		logic [7:0] c;
		begin
			c = 8'h00;
			if (code >= HID_A && code < HID_A + 8'd26) begin
				c = code - HID_A + ASCII_A;
				if (!shift) c = c + CASE_DIFF;
				if (ctrl) c = c & CTRL_CHAR_MASK;
			end else if (code >= HID_1 && code <= HID_0) begin
				if (shift) begin
					case (code)
						8'd30:   c = 8'h21;
						8'd31:   c = 8'h40;
						8'd32:   c = 8'h23;
						8'd33:   c = 8'h24;
						8'd34:   c = 8'h25;
						8'd35:   c = 8'h5E;
						8'd36:   c = 8'h26;
						8'd37:   c = 8'h2A;
						8'd38:   c = 8'h28;
						default: c = 8'h29;
					endcase
				end else if (code == HID_0) begin
					c = ASCII_0;
				end else begin
					c = code - HID_1 + ASCII_1;
				end
			end else begin
				case (code)
					// punctuation
					8'd45:   c = shift ? 8'h5F : 8'h2D;
					8'd46:   c = shift ? 8'h2B : 8'h3D;
					8'd47:   c = shift ? 8'h7B : 8'h5B;
					8'd48:   c = shift ? 8'h7D : 8'h5D;
					8'd49:   c = shift ? 8'h7C : 8'h5C;
					8'd50:   c = shift ? 8'h7E : 8'h23;
					8'd51:   c = shift ? 8'h3A : 8'h3B;
					8'd52:   c = shift ? 8'h22 : 8'h27;
					8'd53:   c = shift ? 8'h7E : 8'h60;
					8'd54:   c = shift ? 8'h3C : 8'h2C;
					8'd55:   c = shift ? 8'h3E : 8'h2E;
					8'd56:   c = shift ? 8'h3F : 8'h2F;
					8'd44:   c = 8'h20;
					8'd100:  c = shift ? 8'h7C : 8'h5C;
					// cursor and editing keys
					8'd80:   c = 8'd1;
					8'd79:   c = 8'd4;
					8'd73:   c = 8'd5;
					8'd78:   c = 8'd6;
					8'd77:   c = 8'd7;
					8'd76:   c = 8'd26;
					8'd43:   c = 8'd9;
					8'd40:   c = 8'd13;
					8'd75:   c = 8'd18;
					8'd81:   c = 8'd19;
					8'd74:   c = 8'd20;
					8'd82:   c = 8'd23;
					8'd41:   c = 8'd27;
					8'd42:   c = 8'd8;
					default: c = 8'h00;
				endcase
			end
			return c;
		end
	endfunction

endpackage

// ===== rtl/keyboard_event_queue_autorepeat.sv =====
// Keyboard event queue with typematic repeat. Items on the s_ side are key
// events, timer ticks, pops and key-state reads (kind in s_tuser); each gives
// exactly one result on the m_ side. The block takes one item per clock while
// the item queue has room: the front maps a press to a character in the accept
// cycle, a two-entry queue holds the classified item, and the back end, while
// the result register is free, applies one item per clock to the key bitmap,
// the 64-entry character memory and the repeat countdown, then loads the
// result register. Back-pressure on m_tready fills the queue and then drops
// s_tready. No clearing pass is needed after reset. Configuration writes
// are taken at any time but must be made while no item is in flight.
module keyboard_event_queue_autorepeat (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pressed[0], key_code[8:1], modifier_bits[16:9], zero pad
	input  logic [1:0]  s_tuser,   // command[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // char_out[7:0], char_available[8], fifo_count[15:9],
	                               // key_is_down[16], held_modifiers[24:17], zero pad
);
	import kbq_pkg::*;

	kbq_cfg_t    cfg_q;
	kbq_qstat_t  q_stat;
	kbq_item_t   push_item;
	kbq_item_t   head_item;
	kbq_result_t result;
	logic        q_push;
	logic        q_pop;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_start  <= 16'd500;
			cfg_q.repeat_period <= 16'd50;
			cfg_q.shift_mask    <= 8'h22;
			cfg_q.control_mask  <= 8'h11;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_REPEAT_START:  cfg_q.repeat_start  <= cfg_data;
				REG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_data;
				REG_SHIFT_MASK:    cfg_q.shift_mask    <= cfg_data[7:0];
				REG_CONTROL_MASK:  cfg_q.control_mask  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	kbq_front u_front (
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.cmd           (cmd_t'(s_tuser)),
		.pressed       (s_tdata[0]),
		.key_code      (s_tdata[8:1]),
		.modifier_bits (s_tdata[16:9]),
		.cfg           (cfg_q),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	kbq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.stat      (q_stat)
	);

	kbq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = {7'd0, result.held_modifiers, result.key_is_down, result.fifo_count,
		result.char_available, result.char_out};

	// the character count never exceeds the memory depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:9] <= COUNT_W'(QUEUE_DEPTH)))
		else $error("fifo_count above queue depth");

	// availability flag agrees with the count
	a_avail_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8] == (m_tdata[15:9] != '0)))
		else $error("char_available disagrees with fifo_count");

	// a popped character leaves room behind it
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[7:0] != 8'h00)) |-> (m_tdata[15:9] != COUNT_W'(QUEUE_DEPTH)))
		else $error("pop reported with a full queue");

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !s_tready)
		else $error("input accepted with the item queue full");

endmodule

// ===== rtl/kbq_front.sv =====
module kbq_front (
	input  logic                in_valid,
	output logic                in_ready,
	input  kbq_pkg::cmd_t       cmd,
	input  logic                pressed,
	input  logic [7:0]          key_code,
	input  logic [7:0]          modifier_bits,
	input  kbq_pkg::kbq_cfg_t   cfg,
	input  kbq_pkg::kbq_qstat_t q_stat,
	output logic                q_push,
	output kbq_pkg::kbq_item_t  q_item
);
	import kbq_pkg::*;

	logic shift;
	logic ctrl;

	// modifier classification
	assign shift = |(modifier_bits & cfg.shift_mask);
	assign ctrl  = |(modifier_bits & cfg.control_mask);

	// take an item whenever the queue has room
	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && !q_stat.full;

	// map presses to characters up front
	always_comb begin
		q_item.cmd  = cmd;
		q_item.down = pressed;
		q_item.code = key_code;
		q_item.mods = modifier_bits;
		q_item.ch   = 8'h00;
		if (cmd == CMD_KEY && pressed) q_item.ch = map_char(key_code, shift, ctrl);
	end

endmodule

// ===== rtl/kbq_queue.sv =====
module kbq_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kbq_pkg::kbq_item_t  push_item,
	input  logic                pop,
	output kbq_pkg::kbq_item_t  head_item,
	output kbq_pkg::kbq_qstat_t stat
);
	import kbq_pkg::*;

	kbq_item_t           entry_q [IQ_DEPTH];
	logic [IQ_PTR_W-1:0] wr_ptr_q;
	logic [IQ_PTR_W-1:0] rd_ptr_q;
	logic [IQ_CNT_W-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign stat.full  = (count_q == IQ_CNT_W'(IQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_item  = entry_q[rd_ptr_q];

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IQ_PTR_W'(IQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IQ_PTR_W'(IQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== rtl/kbq_back.sv =====
module kbq_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kbq_pkg::kbq_cfg_t    cfg,
	input  kbq_pkg::kbq_qstat_t  q_stat,
	input  kbq_pkg::kbq_item_t   q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kbq_pkg::kbq_result_t result
);
	import kbq_pkg::*;

	logic [7:0]              char_mem [QUEUE_DEPTH];
	logic [NUM_KEYCODES-1:0] down_map_q;
	logic [7:0]              mod_q;
	logic [QPTR_W-1:0]       head_q;
	logic [FILL_W-1:0]       fill_q;
	logic [7:0]              rchar_q;
	logic [7:0]              rkey_q;
	logic [TICK_W-1:0]       cd_q;
	logic                    out_valid_q;

	logic [7:0]              rd_q;
	logic                    pop_hit_q;
	logic [FILL_W-1:0]       count_q;
	logic                    is_down_q;
	logic [7:0]              held_q;

	logic                    take;
	logic                    code_ok;
	logic                    push_req;
	logic                    push_en;
	logic [7:0]              push_data;
	logic [SUM_W-1:0]        wsum;
	logic [QPTR_W-1:0]       wr_addr;
	logic                    pop_hit;
	logic                    is_down;
	logic                    map_clr;
	logic                    map_wr;
	logic                    map_val;
	logic [QPTR_W-1:0]       head_d;
	logic [FILL_W-1:0]       fill_d;
	logic [7:0]              mod_d;
	logic [7:0]              rchar_d;
	logic [7:0]              rkey_d;
	logic [TICK_W-1:0]       cd_d;

	// one item per cycle when the result register is free
	assign take      = !q_stat.empty && (!out_valid_q || out_ready);
	assign q_pop     = take;
	assign out_valid = out_valid_q;
	assign code_ok   = (q_item.code != 8'h00) && (32'(q_item.code) < NUM_KEYCODES);

	// tail address, wrapped without a divider
	assign wsum    = SUM_W'(head_q) + SUM_W'(fill_q);
	assign wr_addr = (wsum >= SUM_W'(QUEUE_DEPTH)) ? QPTR_W'(wsum - SUM_W'(QUEUE_DEPTH))
		: QPTR_W'(wsum);
	assign push_en = take && push_req && (fill_q < FILL_W'(QUEUE_DEPTH));

	// item execution
	always_comb begin
		push_req  = 1'b0;
		push_data = 8'h00;
		pop_hit   = 1'b0;
		is_down   = 1'b0;
		map_clr   = 1'b0;
		map_wr    = 1'b0;
		map_val   = 1'b0;
		head_d    = head_q;
		fill_d    = fill_q;
		mod_d     = mod_q;
		rchar_d   = rchar_q;
		rkey_d    = rkey_q;
		cd_d      = cd_q;
		unique case (q_item.cmd)
			CMD_KEY: begin
				if (q_item.code == RESET_CODE) begin
					head_d  = '0;
					fill_d  = '0;
					map_clr = 1'b1;
				end else if (code_ok) begin
					map_wr  = 1'b1;
					map_val = q_item.down;
					if (q_item.down) begin
						mod_d = q_item.mods;
						if (q_item.ch != 8'h00) begin
							rchar_d   = q_item.ch;
							rkey_d    = q_item.code;
							push_req  = 1'b1;
							push_data = q_item.ch;
							cd_d      = cfg.repeat_start;
						end
					end else begin
						mod_d = 8'h00;
						if (q_item.code == rkey_q) rchar_d = 8'h00;
					end
				end
			end
			CMD_TICK: begin
				if (rchar_q != 8'h00) begin
					if (cd_q <= TICK_W'(1)) begin
						push_req  = 1'b1;
						push_data = rchar_q;
						cd_d      = cfg.repeat_period;
					end else begin
						cd_d = cd_q - 1'b1;
					end
				end
			end
			CMD_POP: begin
				if (fill_q != '0) begin
					pop_hit = 1'b1;
					head_d  = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					fill_d  = fill_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (32'(q_item.code) < NUM_KEYCODES) is_down = down_map_q[q_item.code];
			end
			default: ;
		endcase
		if (push_req && fill_q < FILL_W'(QUEUE_DEPTH)) fill_d = fill_q + 1'b1;
	end

	// control state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_map_q  <= '0;
			mod_q       <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			rchar_q     <= '0;
			rkey_q      <= '0;
			cd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (map_clr) down_map_q <= '0;
				else if (map_wr) down_map_q[q_item.code] <= map_val;
				mod_q       <= mod_d;
				head_q      <= head_d;
				fill_q      <= fill_d;
				rchar_q     <= rchar_d;
				rkey_q      <= rkey_d;
				cd_q        <= cd_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// character memory, registered read into the result
	always_ff @(posedge clk) begin
		if (push_en) char_mem[wr_addr] <= push_data;
		if (take) rd_q <= char_mem[head_q];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			pop_hit_q <= pop_hit;
			count_q   <= fill_d;
			is_down_q <= is_down;
			held_q    <= mod_d;
		end
	end

	assign result.char_out       = pop_hit_q ? rd_q : 8'h00;
	assign result.char_available = (count_q != '0);
	assign result.fifo_count     = COUNT_W'(count_q);
	assign result.key_is_down    = is_down_q;
	assign result.held_modifiers = held_q;

endmodule

// ===== dv/keyboard_event_queue_autorepeat_checker.sv =====
`timescale 1ns / 1ps

// Watches the config, input and result channels of the keyboard queue, keeps
// its own copy of the key bitmap, character queue and repeat countdown, and
// compares every result with the oldest predicted one.
module keyboard_event_queue_autorepeat_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          mismatches,
	output int          pending
);
	import kbq_pkg::*;

	// US layout strings, first character in the top byte
	localparam logic [79:0] DIGIT_SHIFTED = ")!@#$%^&*(";
	localparam logic [95:0] PUNCT_PLAIN   = "-=[]\\#;'`,./";
	localparam logic [95:0] PUNCT_SHIFTED = "_+{}|~:\"~<>?";
	localparam logic [7:0]  CH_LOWER_A    = "a";
	localparam logic [7:0]  CH_ZERO       = "0";

	// predicted block state
	kbq_cfg_t                 cfg;
	logic [NUM_KEYCODES-1:0]  key_map;
	logic [7:0]               held_mods;
	logic [7:0]               char_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]        q_head;
	logic [FILL_W-1:0]        q_fill;
	logic [7:0]               rep_char;
	logic [7:0]               rep_key;
	logic [TICK_W-1:0]        rep_count;

	kbq_result_t expected_results [$];
	kbq_result_t predicted;
	kbq_result_t oldest;
	kbq_result_t observed;
	int          err_n = 0;

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	// key code and modifiers to character, 0 when the key has none
	function automatic logic [7:0] ascii_for_key(input logic [7:0] code, input logic [7:0] mods);
		logic       shift;
		logic       ctrl;
		logic [7:0] c;
		int         d;
		shift = |(mods & cfg.shift_mask);
		ctrl  = |(mods & cfg.control_mask);
		c = 8'd0;
		if (code >= 8'd4 && code <= 8'd29) begin
			c = code - 8'd4 + CH_LOWER_A;
			if (shift) c = c - 8'h20;
			if (ctrl) c = c & 8'h1F;
		end else if (code >= 8'd30 && code <= 8'd39) begin
			// digit row runs 1..9 then 0
			d = (code == 8'd39) ? 0 : int'(code) - 29;
			c = shift ? DIGIT_SHIFTED[8*(9-d) +: 8] : CH_ZERO + 8'(d);
		end else if (code >= 8'd45 && code <= 8'd56) begin
			d = int'(code) - 45;
			c = shift ? PUNCT_SHIFTED[8*(11-d) +: 8] : PUNCT_PLAIN[8*(11-d) +: 8];
		end else begin
			case (code)
				8'd44:  c = " ";
				8'd100: c = shift ? "|" : "\\";
				8'd80:  c = 8'd1;   // left
				8'd79:  c = 8'd4;   // right
				8'd73:  c = 8'd5;   // insert
				8'd78:  c = 8'd6;   // page down
				8'd77:  c = 8'd7;   // end
				8'd76:  c = 8'd26;  // delete
				8'd43:  c = 8'd9;   // tab
				8'd40:  c = 8'd13;  // enter
				8'd75:  c = 8'd18;  // page up
				8'd81:  c = 8'd19;  // down
				8'd74:  c = 8'd20;  // home
				8'd82:  c = 8'd23;  // up
				8'd41:  c = 8'd27;  // escape
				8'd42:  c = 8'd8;   // backspace
				default: c = 8'd0;
			endcase
		end
		return c;
	endfunction

	// append to the character queue, dropped when full
	task automatic push_char(input logic [7:0] c);
		if (q_fill < QUEUE_DEPTH) begin
			char_mem[QPTR_W'(q_head + q_fill)] = c;
			q_fill = q_fill + 1'b1;
		end
	endtask

	// apply one item to the predicted state and form its result
	task automatic predict_event(input cmd_t cmd, input logic down, input logic [7:0] code,
		input logic [7:0] mods, output kbq_result_t r);
		logic [7:0] c;
		r = '0;
		case (cmd)
			CMD_KEY: begin
				if (code == RESET_CODE) begin
					q_fill  = '0;
					q_head  = '0;
					key_map = '0;
				end else if (code != 8'd0) begin
					if (down) begin
						key_map[code] = 1'b1;
						held_mods = mods;
						c = ascii_for_key(code, mods);
						if (c != 8'd0) begin
							rep_char  = c;
							rep_key   = code;
							push_char(c);
							rep_count = cfg.repeat_start;
						end
					end else begin
						key_map[code] = 1'b0;
						held_mods = 8'd0;
						if (code == rep_key) rep_char = 8'd0;
					end
				end
			end
			CMD_TICK: begin
				if (rep_char != 8'd0) begin
					if (rep_count <= 1) begin
						push_char(rep_char);
						rep_count = cfg.repeat_period;
					end else begin
						rep_count = rep_count - 1'b1;
					end
				end
			end
			CMD_POP: begin
				if (q_fill != 0) begin
					r.char_out = char_mem[q_head];
					q_head = q_head + 1'b1;
					q_fill = q_fill - 1'b1;
				end
			end
			default: r.key_is_down = key_map[code];
		endcase
		r.char_available = (q_fill != 0);
		r.fifo_count     = COUNT_W'(q_fill);
		r.held_modifiers = held_mods;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			err_n++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg.repeat_start  = 16'd500;
			cfg.repeat_period = 16'd50;
			cfg.shift_mask    = 8'h22;
			cfg.control_mask  = 8'h11;
			key_map   = '0;
			held_mods = 8'd0;
			q_head    = '0;
			q_fill    = '0;
			rep_char  = 8'd0;
			rep_key   = 8'd0;
			rep_count = '0;
			expected_results.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_REPEAT_START:  cfg.repeat_start  = cfg_data;
					REG_REPEAT_PERIOD: cfg.repeat_period = cfg_data;
					REG_SHIFT_MASK:    cfg.shift_mask    = cfg_data[7:0];
					REG_CONTROL_MASK:  cfg.control_mask  = cfg_data[7:0];
				endcase
			end

			// accepted input item
			if (s_tvalid && s_tready) begin
				predict_event(cmd_t'(s_tuser), s_tdata[0], s_tdata[8:1], s_tdata[16:9], predicted);
				expected_results.push_back(predicted);
			end

			// accepted result item
			if (m_tvalid && m_tready) begin
				observed.char_out       = m_tdata[7:0];
				observed.char_available = m_tdata[8];
				observed.fifo_count     = m_tdata[15:9];
				observed.key_is_down    = m_tdata[16];
				observed.held_modifiers = m_tdata[24:17];
				if (expected_results.size() == 0) begin
					err_n++;
					$display("%0t: result with nothing expected, expected none, actual %h",
						$time, m_tdata);
				end else begin
					oldest = expected_results.pop_front();
					check_field("char_out", oldest.char_out, observed.char_out);
					check_field("char_available", oldest.char_available, observed.char_available);
					check_field("fifo_count", oldest.fifo_count, observed.fifo_count);
					check_field("key_is_down", oldest.key_is_down, observed.key_is_down);
					check_field("held_modifiers", oldest.held_modifiers, observed.held_modifiers);
				end
			end
		end
		pending    <= expected_results.size();
		mismatches <= err_n;
	end

endmodule

// ===== dv/keyboard_event_queue_autorepeat_tb.sv =====
`timescale 1ns / 1ps

module keyboard_event_queue_autorepeat_tb;
	import kbq_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	// key codes used by the directed part
	localparam logic [7:0] KEY_A      = 8'd4;
	localparam logic [7:0] KEY_B      = 8'd5;
	localparam logic [7:0] KEY_Z      = 8'd29;
	localparam logic [7:0] KEY_1      = 8'd30;
	localparam logic [7:0] KEY_0      = 8'd39;
	localparam logic [7:0] KEY_ESC    = 8'd41;
	localparam logic [7:0] KEY_BLANK  = 8'd44;
	localparam logic [7:0] KEY_HYPHEN = 8'd45;
	localparam logic [7:0] KEY_QMARK  = 8'd56;
	localparam logic [7:0] KEY_NUHS   = 8'd100;
	localparam logic [7:0] KEY_LSHIFT = 8'd225;
	localparam logic [7:0] KEY_NONE   = 8'd0;

	typedef enum int {RX_OPEN, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	int         mismatches;
	int         pending;
	int         hold_cnt   = 0;
	int         burst_left = 1;
	int         quiet      = 0;
	logic [7:0] last_code  = 8'd4;

	keyboard_event_queue_autorepeat u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	keyboard_event_queue_autorepeat_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// result side: stall pattern switches among a few modes, long hold on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_seen;
		m_tready  = 1'b0;
		mode      = RX_OPEN;
		mode_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_cnt) begin
				hold_seen = hold_cnt;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 200);
			end
			mode_left--;
			case (mode)
				RX_OPEN:     m_tready <= 1'b1;
				RX_MOSTLY:   m_tready <= ($urandom_range(0, 99) < 70);
				RX_PERIODIC: m_tready <= (mode_left % 4 == 0);
				default:     m_tready <= ($urandom_range(0, 99) < 15);
			endcase
		end
	end

	// watchdog on cycles with no item moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// offer one item, wait for it to be taken, then pace the next one
	task automatic send(input cmd_t cmd, input logic down, input logic [7:0] code,
		input logic [7:0] mods);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, mods, code, down};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) :
				$urandom_range(1, 16);
		end
	endtask

	task automatic key_event(input logic down, input logic [7:0] code, input logic [7:0] mods);
		send(CMD_KEY, down, code, mods);
	endtask

	// ticks and pops carry junk in the unused fields
	task automatic tick_item();
		send(CMD_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic pop_item();
		send(CMD_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic read_key(input logic [7:0] code);
		send(CMD_READ, 1'($urandom_range(0, 1)), code, 8'($urandom_range(0, 255)));
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [15:0] start, input logic [15:0] period,
		input logic [7:0] smask, input logic [7:0] cmask);
		drain();
		put_reg(REG_REPEAT_START, start);
		put_reg(REG_REPEAT_PERIOD, period);
		put_reg(REG_SHIFT_MASK, {8'd0, smask});
		put_reg(REG_CONTROL_MASK, {8'd0, cmask});
		cfg_valid <= 1'b0;
	endtask

	// weighted random item; key events mostly press a mapped key or release the last one
	task automatic random_item(input int key_w, input int tick_w, input int pop_w);
		int         r;
		int         k;
		logic [7:0] code;
		logic [7:0] mods;
		logic       down;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0:       mods = 8'h00;
			1:       mods = 8'($urandom_range(0, 255));
			2:       mods = 8'h02;
			default: mods = 8'h01;
		endcase
		if (r < key_w) begin
			k = $urandom_range(0, 99);
			down = 1'($urandom_range(0, 1));
			if (k < 45) begin
				down = 1'b1;
				code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(73, 82)) :
					8'($urandom_range(4, 56));
				if ($urandom_range(0, 19) == 0) code = KEY_NUHS;
				last_code = code;
			end else if (k < 75) begin
				down = 1'b0;
				code = last_code;
			end else if (k < 85) begin
				code = 8'($urandom_range(0, 255));
			end else if (k < 92) begin
				// modifier keys map to no character
				code = 8'($urandom_range(224, 231));
			end else if (k < 96) begin
				code = KEY_NONE;
			end else begin
				code = RESET_CODE;
			end
			key_event(down, code, mods);
		end else if (r < key_w + tick_w) begin
			tick_item();
		end else if (r < key_w + tick_w + pop_w) begin
			pop_item();
		end else begin
			read_key($urandom_range(0, 1) ? last_code : 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_phase(input int n, input int key_w, input int tick_w, input int pop_w,
		input bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == n / 3) hold_cnt <= hold_cnt + 1;
			random_item(key_w, tick_w, pop_w);
		end
	endtask

	task automatic random_config();
		set_config(16'($urandom_range(1, 20)), 16'($urandom_range(1, 8)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_REPEAT_START;
		cfg_data  = 16'd0;
		s_tvalid  = 1'b0;
		s_tdata   = 24'd0;
		s_tuser   = CMD_KEY;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// default registers: mapping tables, empty pop, state reads, reset code
		read_key(KEY_A);
		pop_item();
		key_event(1'b1, KEY_A, 8'h00);
		key_event(1'b1, KEY_Z, 8'h02);
		key_event(1'b1, KEY_A, 8'h10);
		key_event(1'b1, KEY_1, 8'h00);
		key_event(1'b1, KEY_0, 8'h20);
		// modifier outside the shift mask keeps the plain form
		key_event(1'b1, KEY_HYPHEN, 8'h80);
		key_event(1'b1, KEY_NUHS, 8'h02);
		key_event(1'b1, KEY_ESC, 8'h00);
		key_event(1'b1, KEY_BLANK, 8'h22);
		key_event(1'b1, KEY_LSHIFT, 8'h02);
		read_key(KEY_LSHIFT);
		read_key(KEY_NONE);
		read_key(RESET_CODE);
		key_event(1'b1, KEY_NONE, 8'hFF);
		key_event(1'b0, KEY_LSHIFT, 8'h5A);
		pop_item();
		pop_item();
		pop_item();
		key_event(1'b1, RESET_CODE, 8'h00);
		read_key(KEY_A);
		pop_item();
		key_event(1'b0, RESET_CODE, 8'hFF);

		// short repeat: first repeat after three ticks, then every tick
		set_config(16'd3, 16'd1, 8'h22, 8'h11);
		key_event(1'b1, KEY_A, 8'h00);
		repeat (5) tick_item();
		key_event(1'b0, KEY_B, 8'h00);
		tick_item();
		key_event(1'b0, KEY_A, 8'h00);
		repeat (2) tick_item();
		key_event(1'b1, KEY_LSHIFT, 8'h20);
		key_event(1'b1, KEY_1, 8'h00);
		key_event(1'b0, KEY_LSHIFT, 8'h00);
		repeat (3) tick_item();
		repeat (4) pop_item();

		// zero start and period act like one; every modifier is shift, none is control
		set_config(16'd0, 16'd0, 8'hFF, 8'h00);
		key_event(1'b1, KEY_QMARK, 8'h04);
		repeat (2) tick_item();
		key_event(1'b1, KEY_A, 8'hFF);
		repeat (3) tick_item();
		key_event(1'b0, KEY_QMARK, 8'h00);
		tick_item();
		random_phase(150, 30, 50, 10, 1'b0);

		// longest countdowns, no shift bits, every modifier is control
		set_config(16'hFFFF, 16'hFFFF, 8'h00, 8'hFF);
		random_phase(150, 35, 25, 20, 1'b0);

		// tick heavy with few pops to fill the queue, long result stall a third of the way in
		set_config(16'd1, 16'd1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_phase(250, 20, 70, 3, 1'b1);

		// pop heavy to empty it again
		random_config();
		random_phase(250, 30, 25, 35, 1'b0);

		for (int p = 0; p < 3; p++) begin
			random_config();
			random_phase(200, 30, 40, $urandom_range(5, 30), 1'b0);
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
